// ===== hw/rtl/rpnh_pkg.sv =====
`default_nettype none
// Shared types and constants of the ray and polyline nearest-hit unit.
package rpnh_pkg;

  // Field widths of the stream words.
  localparam int COORD_W = 48;
  localparam int DIR_W   = 32;

  // Exact arithmetic width and iteration counts of the serial units.
  localparam int WIDE_W   = 192;
  localparam int MUL_BITS = 50;
  localparam int DIV_BITS = 130;
  localparam int DIR_FRAC = 30;
  localparam int CAP_INT  = 100000;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Input kinds; the reserved kind is dropped by the front.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef logic signed [WIDE_W-1:0] wide_t;

  // One classified word as it travels through the queue.
  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [DIR_W-1:0]   dc;
    logic signed [DIR_W-1:0]   ds;
    logic signed [COORD_W-1:0] fb;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_LD0,
    B_LD1,
    B_SEG,
    B_MUL,
    B_CHK,
    B_DIV,
    B_CMP,
    B_DONE
  } bstate_t;

  // Sign extension to the exact arithmetic width.
  function automatic wide_t sx48(input logic signed [COORD_W-1:0] v);
    return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic wide_t sx32(input logic signed [DIR_W-1:0] v);
    return {{(WIDE_W-DIR_W){v[DIR_W-1]}}, v};
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return v[WIDE_W-1] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rpnh_queue.sv =====
`default_nettype none
// Short queue of classified words between the front and the back.
module rpnh_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rpnh_pkg::item_t push_item,
  input  wire logic            pop,
  output rpnh_pkg::item_t      pop_item,
  output rpnh_pkg::qstat_t     stat
);

  rpnh_pkg::item_t                slots_r [rpnh_pkg::QUEUE_DEPTH];
  logic [rpnh_pkg::QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [rpnh_pkg::QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [rpnh_pkg::QPTR_W:0]      fill_r, fill_nxt;

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_nxt = push ? wptr_r + rpnh_pkg::QPTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + rpnh_pkg::QPTR_W'(1) : rptr_r;
    fill_nxt = fill_r + (rpnh_pkg::QPTR_W+1)'(push) - (rpnh_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_item;
    end
  end

  assign pop_item   = slots_r[rptr_r];
  assign stat.full  = (fill_r == (rpnh_pkg::QPTR_W+1)'(rpnh_pkg::QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/rpnh_front.sv =====
`default_nettype none
// Front end: takes input words, classifies them and drops reserved kinds.
module rpnh_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: point_x, point_y, dir_cos, dir_sin, fallback_len.
  input  wire logic [207:0]     in_tdata,
  // Fields from bit 0 up: mode.
  input  wire logic [1:0]       in_tuser,
  input  wire rpnh_pkg::qstat_t q_stat,
  output logic                  push,
  output rpnh_pkg::item_t       push_item
);

  logic            valid_r, valid_nxt;
  rpnh_pkg::item_t item_r;
  logic            accept;

  // Handshake of the holding register.
  always_comb begin
    push      = valid_r && !q_stat.full;
    in_tready = !valid_r || !q_stat.full;
    accept    = in_tvalid && in_tready;
    valid_nxt = (valid_r && !push) || (accept && (in_tuser != rpnh_pkg::MODE_RESERVED));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Unpack the word into its classified form.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd <= rpnh_pkg::cmd_t'(in_tuser);
      item_r.px  <= in_tdata[47:0];
      item_r.py  <= in_tdata[95:48];
      item_r.dc  <= in_tdata[127:96];
      item_r.ds  <= in_tdata[159:128];
      item_r.fb  <= in_tdata[207:160];
    end
  end

  assign push_item = item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rpnh_back.sv =====
`default_nettype none
// Back end: vertex store and the serial segment intersection engine.
module rpnh_back #(
  parameter int MAX_VERTICES    = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rpnh_pkg::qstat_t q_stat,
  input  wire rpnh_pkg::item_t  q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // Fields from bit 0 up: distance.
  output logic [47:0]           out_tdata,
  // Fields from bit 0 up: hit, overflowed.
  output logic [1:0]            out_tuser
);

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int W      = rpnh_pkg::WIDE_W;
  localparam int CW     = rpnh_pkg::COORD_W;
  localparam int DW     = rpnh_pkg::DIR_W;
  localparam rpnh_pkg::wide_t CAP_W = rpnh_pkg::wide_t'(rpnh_pkg::CAP_INT) << COORD_FRAC_BITS;
  localparam logic signed [CW-1:0] LIM_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] LIM_LO = {1'b1, {(CW-1){1'b0}}};

  // Vertex store.
  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];
  logic signed [CW-1:0] rdx_r, rdy_r;

  rpnh_pkg::bstate_t    state_r, state_nxt;
  logic [CNT_W-1:0]     vcount_r, idx_r;
  logic                 ovf_r;

  // Query operands and segment end points.
  logic signed [CW-1:0] ox_r, oy_r, fb_r;
  logic signed [DW-1:0] dc_r, ds_r;
  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r;

  rpnh_pkg::wide_t      num_r, den_r, t_r, hx_r, hy_r, tmin_r;
  logic                 hit_r;

  // Shift-add multiplier and restoring divider registers.
  rpnh_pkg::wide_t      mc_r, acc_r;
  logic [rpnh_pkg::MUL_BITS-1:0] mp_r;
  logic                 msign_r;
  logic [2:0]           step_r;
  rpnh_pkg::wide_t      dvd_r, dsr_r, rem_r, quo_r;
  logic                 dsign_r;
  logic [7:0]           cnt_r;

  logic                 out_valid_r;
  logic signed [CW-1:0] dist_r;
  logic                 ohit_r, oovf_r;

  // Sequencer controls.
  logic                 ld_mul, rd_en, wr_en, more_seg;
  logic [2:0]           ld_step;
  logic [ADDR_W-1:0]    rd_addr;
  rpnh_pkg::wide_t      mul_a, mul_b, mul_add, mul_res;
  rpnh_pkg::wide_t      rem_sh, rem_new, quo_new, div_res;
  logic                 mul_last, div_last, div_ge, box_ok;
  rpnh_pkg::wide_t      dx, dy;

  function automatic logic in_box(input rpnh_pkg::wide_t p, input logic signed [CW-1:0] a,
                                  input logic signed [CW-1:0] b);
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (p >= rpnh_pkg::sx48(lo)) && (p <= rpnh_pkg::sx48(hi));
  endfunction

  // Datapath arithmetic of one serial step.
  always_comb begin
    dx       = rpnh_pkg::sx48(x1_r) - rpnh_pkg::sx48(x0_r);
    dy       = rpnh_pkg::sx48(y1_r) - rpnh_pkg::sx48(y0_r);
    mul_add  = mp_r[0] ? acc_r + mc_r : acc_r;
    mul_res  = msign_r ? -mul_add : mul_add;
    mul_last = (cnt_r == 8'(rpnh_pkg::MUL_BITS - 1));
    rem_sh   = {rem_r[W-2:0], dvd_r[rpnh_pkg::DIV_BITS-1]};
    div_ge   = $unsigned(rem_sh) >= $unsigned(dsr_r);
    rem_new  = div_ge ? rem_sh - dsr_r : rem_sh;
    quo_new  = {quo_r[W-2:0], div_ge};
    div_res  = dsign_r ? -quo_new : quo_new;
    div_last = (cnt_r == 8'(rpnh_pkg::DIV_BITS - 1));
    box_ok   = in_box(hx_r, x0_r, x1_r) && in_box(hy_r, y0_r, y1_r);
    more_seg = ({1'b0, idx_r} + (CNT_W+1)'(2)) < {1'b0, vcount_r};
    wr_en    = (state_r == rpnh_pkg::B_IDLE) && !q_stat.empty &&
               (q_item.cmd == rpnh_pkg::CMD_APPEND) &&
               (vcount_r < CNT_W'(MAX_VERTICES));
  end

  // Sequencer next state and controls.
  always_comb begin
    state_nxt = state_r;
    ld_mul    = 1'b0;
    ld_step   = step_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    q_pop     = 1'b0;
    unique case (state_r)
      rpnh_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_item.cmd == rpnh_pkg::CMD_QUERY) begin
            if (vcount_r < CNT_W'(2)) begin
              state_nxt = rpnh_pkg::B_DONE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = rpnh_pkg::B_LD0;
            end
          end
        end
      end
      rpnh_pkg::B_LD0: begin
        rd_en     = 1'b1;
        rd_addr   = ADDR_W'(idx_r + CNT_W'(1));
        state_nxt = rpnh_pkg::B_LD1;
      end
      rpnh_pkg::B_LD1: begin
        state_nxt = rpnh_pkg::B_SEG;
      end
      rpnh_pkg::B_SEG: begin
        ld_mul    = 1'b1;
        ld_step   = 3'd0;
        state_nxt = rpnh_pkg::B_MUL;
      end
      rpnh_pkg::B_MUL: begin
        if (mul_last) begin
          unique case (step_r)
            3'd3:    state_nxt = rpnh_pkg::B_CHK;
            3'd5:    state_nxt = rpnh_pkg::B_CMP;
            default: begin
              ld_mul  = 1'b1;
              ld_step = step_r + 3'd1;
            end
          endcase
        end
      end
      rpnh_pkg::B_CHK: begin
        if (den_r != '0) begin
          state_nxt = rpnh_pkg::B_DIV;
        end else if (more_seg) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(idx_r + CNT_W'(2));
          state_nxt = rpnh_pkg::B_LD1;
        end else begin
          state_nxt = rpnh_pkg::B_DONE;
        end
      end
      rpnh_pkg::B_DIV: begin
        if (div_last) begin
          ld_mul    = 1'b1;
          ld_step   = 3'd4;
          state_nxt = rpnh_pkg::B_MUL;
        end
      end
      rpnh_pkg::B_CMP: begin
        if (more_seg) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(idx_r + CNT_W'(2));
          state_nxt = rpnh_pkg::B_LD1;
        end else begin
          state_nxt = rpnh_pkg::B_DONE;
        end
      end
      rpnh_pkg::B_DONE: begin
        if (!out_valid_r) begin
          state_nxt = rpnh_pkg::B_IDLE;
        end
      end
      default: state_nxt = rpnh_pkg::B_IDLE;
    endcase
  end

  // Operand selection of the multiplier for each product.
  always_comb begin
    unique case (ld_step)
      3'd0: begin
        mul_a = dx;
        mul_b = rpnh_pkg::sx48(oy_r) - rpnh_pkg::sx48(y0_r);
      end
      3'd1: begin
        mul_a = dy;
        mul_b = rpnh_pkg::sx48(ox_r) - rpnh_pkg::sx48(x0_r);
      end
      3'd2: begin
        mul_a = dy;
        mul_b = rpnh_pkg::sx32(dc_r);
      end
      3'd3: begin
        mul_a = dx;
        mul_b = rpnh_pkg::sx32(ds_r);
      end
      3'd4: begin
        mul_a = (state_r == rpnh_pkg::B_DIV) ? div_res : t_r;
        mul_b = rpnh_pkg::sx32(dc_r);
      end
      default: begin
        mul_a = t_r;
        mul_b = rpnh_pkg::sx32(ds_r);
      end
    endcase
  end

  // Vertex store write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[vcount_r[ADDR_W-1:0]] <= q_item.px;
      mem_y[vcount_r[ADDR_W-1:0]] <= q_item.py;
    end
    if (rd_en) begin
      rdx_r <= mem_x[rd_addr];
      rdy_r <= mem_y[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpnh_pkg::B_IDLE;
      vcount_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == rpnh_pkg::B_IDLE) && !q_stat.empty) begin
        if (q_item.cmd == rpnh_pkg::CMD_CLEAR) begin
          vcount_r <= '0;
        end else if (q_item.cmd == rpnh_pkg::CMD_APPEND) begin
          if (wr_en) begin
            vcount_r <= vcount_r + CNT_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if ((state_r == rpnh_pkg::B_DONE) && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Engine datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      rpnh_pkg::B_IDLE: begin
        ox_r   <= q_item.px;
        oy_r   <= q_item.py;
        dc_r   <= q_item.dc;
        ds_r   <= q_item.ds;
        fb_r   <= q_item.fb;
        tmin_r <= CAP_W;
        hit_r  <= 1'b0;
        idx_r  <= '0;
      end
      rpnh_pkg::B_LD0: begin
        x0_r <= rdx_r;
        y0_r <= rdy_r;
      end
      rpnh_pkg::B_LD1: begin
        x1_r <= rdx_r;
        y1_r <= rdy_r;
      end
      rpnh_pkg::B_MUL: begin
        // A new product loaded below takes over the shift registers.
        if (!ld_mul) begin
          acc_r <= mul_add;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
          cnt_r <= cnt_r + 8'd1;
        end
        if (mul_last) begin
          unique case (step_r)
            3'd0:    num_r <= mul_res;
            3'd1:    num_r <= num_r - mul_res;
            3'd2:    den_r <= mul_res;
            3'd3:    den_r <= den_r - mul_res;
            3'd4:    hx_r  <= rpnh_pkg::sx48(ox_r) + (mul_res >>> rpnh_pkg::DIR_FRAC);
            default: hy_r  <= rpnh_pkg::sx48(oy_r) + (mul_res >>> rpnh_pkg::DIR_FRAC);
          endcase
        end
      end
      rpnh_pkg::B_CHK: begin
        dvd_r   <= rpnh_pkg::wabs(num_r) << rpnh_pkg::DIR_FRAC;
        dsr_r   <= rpnh_pkg::wabs(den_r);
        rem_r   <= '0;
        quo_r   <= '0;
        dsign_r <= num_r[W-1] ^ den_r[W-1];
        cnt_r   <= '0;
        if (den_r == '0) begin
          x0_r  <= x1_r;
          y0_r  <= y1_r;
          idx_r <= idx_r + CNT_W'(1);
        end
      end
      rpnh_pkg::B_DIV: begin
        dvd_r <= dvd_r << 1;
        rem_r <= rem_new;
        quo_r <= quo_new;
        if (!ld_mul) begin
          cnt_r <= cnt_r + 8'd1;
        end
        if (div_last) begin
          t_r <= div_res;
        end
      end
      rpnh_pkg::B_CMP: begin
        if (box_ok) begin
          hit_r <= 1'b1;
          if ($unsigned(rpnh_pkg::wabs(tmin_r)) > $unsigned(rpnh_pkg::wabs(t_r))) begin
            tmin_r <= t_r;
          end
        end
        x0_r  <= x1_r;
        y0_r  <= y1_r;
        idx_r <= idx_r + CNT_W'(1);
      end
      rpnh_pkg::B_DONE: begin
        if (!out_valid_r) begin
          ohit_r <= hit_r;
          oovf_r <= ovf_r;
          if (!hit_r) begin
            dist_r <= fb_r;
          end else if (tmin_r > rpnh_pkg::sx48(LIM_HI)) begin
            dist_r <= LIM_HI;
          end else if (tmin_r < rpnh_pkg::sx48(LIM_LO)) begin
            dist_r <= LIM_LO;
          end else begin
            dist_r <= tmin_r[CW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    // Multiplier setup for the next product.
    if (ld_mul) begin
      mc_r    <= rpnh_pkg::wabs(mul_a);
      mp_r    <= rpnh_pkg::MUL_BITS'(rpnh_pkg::wabs(mul_b));
      msign_r <= mul_a[W-1] ^ mul_b[W-1];
      acc_r   <= '0;
      cnt_r   <= '0;
      step_r  <= ld_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dist_r;
  assign out_tuser  = {oovf_r, ohit_r};

endmodule
`default_nettype wire

// ===== hw/rtl/ray_polyline_nearest_hit_unit.sv =====
// Clear and append words are handled in the back end directly from the queue;
// a query runs each segment through the shift-add multiplier (six products)
// and the restoring divider. A parallel segment skips the divider and the
// last two products. A front register and a four-word queue keep accepting
// words while a query runs, as long as the queue has room. Reset is synchronous,
// active low, and empties the store, the queue and the overflow flag.
`default_nettype none
module ray_polyline_nearest_hit_unit #(
  parameter int MAX_VERTICES    = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // Fields from bit 0 up: point_x, point_y, dir_cos, dir_sin, fallback_len.
  input  wire logic [207:0] in_tdata,
  // Fields from bit 0 up: mode.
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // Fields from bit 0 up: distance.
  output logic [47:0]       out_tdata,
  // Fields from bit 0 up: hit, overflowed.
  output logic [1:0]        out_tuser
);

  logic             push, pop;
  rpnh_pkg::item_t  push_item, pop_item;
  rpnh_pkg::qstat_t q_stat;

  // Classifying front end.
  rpnh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Word queue between the two sides.
  rpnh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // Store and intersection engine.
  rpnh_back #(
    .MAX_VERTICES    (MAX_VERTICES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (pop_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
